FILE: rtl/urd_pkg.sv
// shared constants and types for the unsigned restoring divider
package urd_pkg;

	// operand and result port width
	localparam int DATA_W = 64;

	// default number of active operand bits
	localparam int DEF_WIDTH = 64;

	// control that travels down the pipeline beside the data
	typedef struct packed {
		logic valid;
		logic zero;
	} ctrl_t;

endpackage

FILE: rtl/unsigned_restoring_divider_core.sv
// top level of the pipelined unsigned restoring divider
//
// Divides the low WIDTH bits of dividend by the low WIDTH bits of divisor and
// returns the truncated quotient, zero-extended to 64 bits. A zero divisor
// gives a quotient of zero with no flag. The core takes a new transfer on every
// clock edge where start is high (busy is always low), and each result appears
// on quotient for exactly one cycle with done high, once its operands have
// passed through the chain of WIDTH subtract-and-compare stages, one per
// quotient bit. Throughput is one division per cycle. Results cannot be held
// off, so the receiver must take quotient in the cycle that done is high.
module unsigned_restoring_divider_core #(
	parameter int WIDTH = urd_pkg::DEF_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [urd_pkg::DATA_W-1:0] dividend,
	input  logic [urd_pkg::DATA_W-1:0] divisor,
	output logic                       done,
	output logic [urd_pkg::DATA_W-1:0] quotient
);

	// per-stage links: index 0 is the input side, index WIDTH the last register
	urd_pkg::ctrl_t   ctrl_p [0:WIDTH];
	logic [WIDTH-1:0] rem_p  [0:WIDTH];
	logic [WIDTH-1:0] nq_p   [0:WIDTH];
	logic [WIDTH-1:0] den_p  [0:WIDTH];

	// the pipeline never stalls, so the core is never busy
	assign busy = 1'b0;

	// feed the first stage straight from the ports, only the low WIDTH bits count
	assign ctrl_p[0].valid = start;
	assign ctrl_p[0].zero  = (divisor[WIDTH-1:0] == '0);
	assign rem_p[0]        = '0;
	assign nq_p[0]         = dividend[WIDTH-1:0];
	assign den_p[0]        = divisor[WIDTH-1:0];

	// one stage per quotient bit, most significant bit first; the dividend
	// shifts out of the top of nq while quotient bits shift in at the bottom
	for (genvar i = 0; i < WIDTH; i++) begin : g_stage
		urd_stage #(
			.WIDTH(WIDTH)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl_in (ctrl_p[i]),
			.rem_in  (rem_p[i]),
			.nq_in   (nq_p[i]),
			.den_in  (den_p[i]),
			.ctrl_out(ctrl_p[i+1]),
			.rem_out (rem_p[i+1]),
			.nq_out  (nq_p[i+1]),
			.den_out (den_p[i+1])
		);
	end

	// the final remainder is dropped; a zero divisor forces the quotient to zero
	assign done     = ctrl_p[WIDTH].valid;
	assign quotient = urd_pkg::DATA_W'(ctrl_p[WIDTH].zero ? '0 : nq_p[WIDTH]);

	// every result comes from an earlier transfer on start
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, WIDTH))
		else $error("result without a matching transfer");

	// a zero divisor yields a zero quotient
	a_zero_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && (divisor[WIDTH-1:0] == '0), WIDTH)) |-> (quotient == '0))
		else $error("nonzero quotient for zero divisor");

	// quotient bits above WIDTH stay clear
	a_upper_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((quotient >> WIDTH) == '0))
		else $error("quotient exceeds WIDTH bits");

endmodule

FILE: rtl/urd_stage.sv
// one pipeline stage of the divider: a single restoring shift-and-subtract step
module urd_stage #(
	parameter int WIDTH = urd_pkg::DEF_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  urd_pkg::ctrl_t     ctrl_in,
	input  logic [WIDTH-1:0]   rem_in,
	input  logic [WIDTH-1:0]   nq_in,
	input  logic [WIDTH-1:0]   den_in,
	output urd_pkg::ctrl_t     ctrl_out,
	output logic [WIDTH-1:0]   rem_out,
	output logic [WIDTH-1:0]   nq_out,
	output logic [WIDTH-1:0]   den_out
);

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             ge;
	logic [WIDTH-1:0] rem_next;
	logic [WIDTH-1:0] nq_next;

	urd_pkg::ctrl_t   ctrl_s1;
	logic [WIDTH-1:0] rem_s1;
	logic [WIDTH-1:0] nq_s1;
	logic [WIDTH-1:0] den_s1;

	// shift next dividend bit into the remainder, keep the carry bit
	always_comb begin
		trial    = {rem_in, nq_in[WIDTH-1]};
		diff     = trial - {1'b0, den_in};
		ge       = ~diff[WIDTH];
		rem_next = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
		nq_next  = {nq_in[WIDTH-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_in;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (ctrl_in.valid) begin
			rem_s1 <= rem_next;
			nq_s1  <= nq_next;
			den_s1 <= den_in;
		end
	end

	assign ctrl_out = ctrl_s1;
	assign rem_out  = rem_s1;
	assign nq_out   = nq_s1;
	assign den_out  = den_s1;

endmodule
